// ===== rtl/playfair_digraph_encryptor_top_assert.svh =====
// Assertion macros for the Playfair digraph encryptor top level.
// Included by playfair_digraph_encryptor_top.sv; expects clk_i and rst_ni in scope.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_TOP_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PDE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pde_pkg.sv =====
// Shared types, constants and square-geometry helpers for the Playfair encryptor.
// No dependencies; imported by playfair_digraph_encryptor_top.
`timescale 1ns / 1ps

package pde_pkg;

  // Square and alphabet geometry.
  localparam int Side     = 5;
  localparam int Cells    = Side * Side;
  localparam int Alpha    = 26;
  localparam int LetterW  = 5;
  localparam int PosW     = 5;
  localparam int RowW     = 3;
  localparam int CipherW  = 7;

  // Letter indices of interest (A is zero).
  localparam logic [LetterW-1:0] LetterI = 5'd8;
  localparam logic [LetterW-1:0] LetterJ = 5'd9;
  localparam logic [LetterW-1:0] LetterX = 5'd23;

  // ASCII anchors.
  localparam logic [7:0]         AsciiUpA  = 8'h41;
  localparam logic [7:0]         AsciiUpZ  = 8'h5A;
  localparam logic [7:0]         AsciiLowA = 8'h61;
  localparam logic [7:0]         AsciiLowZ = 8'h7A;
  localparam logic [CipherW-1:0] CipherA   = 7'h41;

  // Kind of an input word, carried in tuser.
  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_KEY_END  = 2'd1,
    KIND_TEXT     = 2'd2,
    KIND_TEXT_END = 2'd3
  } kind_e;

  // Decoded character: valid flag plus letter index with J folded to I.
  typedef struct packed {
    logic               vld;
    logic [LetterW-1:0] idx;
  } letter_t;

  function automatic letter_t letter_of(logic [7:0] sym);
    letter_t res;
    res.vld = 1'b1;
    res.idx = '0;
    priority if (sym >= AsciiLowA && sym <= AsciiLowZ) begin
      res.idx = LetterW'(sym - AsciiLowA);
    end else if (sym >= AsciiUpA && sym <= AsciiUpZ) begin
      res.idx = LetterW'(sym - AsciiUpA);
    end else begin
      res.vld = 1'b0;
    end
    if (res.idx == LetterJ) begin
      res.idx = LetterI;
    end
    return res;
  endfunction

  // Row of a square position, found by comparing against row starts.
  function automatic logic [RowW-1:0] pos_row(logic [PosW-1:0] p);
    logic [RowW-1:0] r;
    priority if (p >= PosW'(4 * Side)) begin
      r = RowW'(4);
    end else if (p >= PosW'(3 * Side)) begin
      r = RowW'(3);
    end else if (p >= PosW'(2 * Side)) begin
      r = RowW'(2);
    end else if (p >= PosW'(Side)) begin
      r = RowW'(1);
    end else begin
      r = RowW'(0);
    end
    return r;
  endfunction

  // First position of a row: row * 5 as a shift and an add.
  function automatic logic [PosW-1:0] row_base(logic [RowW-1:0] r);
    logic [PosW-1:0] rw;
    rw = PosW'(r);
    return PosW'((rw << 2) + rw);
  endfunction

  function automatic logic [RowW-1:0] pos_col(logic [PosW-1:0] p);
    logic [PosW-1:0] diff;
    diff = p - row_base(pos_row(p));
    return RowW'(diff);
  endfunction

  // Step one row or column forward, wrapping at the square edge.
  function automatic logic [RowW-1:0] wrap_inc(logic [RowW-1:0] x);
    return (x == RowW'(Side - 1)) ? '0 : RowW'(x + RowW'(1));
  endfunction

endpackage

// ===== rtl/pde_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the square and letter-position tables.
`timescale 1ns / 1ps

module pde_ram #(
  parameter int Width = 5,
  parameter int Depth = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/playfair_digraph_encryptor_top.sv =====
// Playfair digraph encryptor: key square build, plaintext pairing and pair encryption.
// Depends on pde_pkg, pde_ram and playfair_digraph_encryptor_top_assert.svh.
// A key character is taken while idle; a key end runs an alphabet sweep from A to Z.
// A plaintext word that completes a pair passes through states PA, PB, PC, SA, SB and OUT,
// which carry out four sequential reads through the single read ports of the two tables.
// Input waits for a pair's result to load; other words are taken one per cycle outside a sweep.
// Reset (rst_ni low, asynchronous) clears the square fill, pairing and handshake state; no sweep.
`timescale 1ns / 1ps

module playfair_digraph_encryptor_top
  import pde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [6:0] first_cipher, [13:7] second_cipher, [15:14] zero
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_PA   = 3'd2;
  localparam logic [2:0] ST_PB   = 3'd3;
  localparam logic [2:0] ST_PC   = 3'd4;
  localparam logic [2:0] ST_SA   = 3'd5;
  localparam logic [2:0] ST_SB   = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [Alpha-1:0]   used_q, used_d;
  logic [PosW-1:0]    fill_q, fill_d;
  logic [LetterW-1:0] sweep_q, sweep_d;
  logic               ready_q, ready_d;
  logic [LetterW-1:0] pend_q, pend_d;
  logic               pend_vld_q, pend_vld_d;
  logic [LetterW-1:0] a_q, a_d;
  logic [LetterW-1:0] b_q, b_d;
  logic [PosW-1:0]    pa_q, pa_d;
  logic [PosW-1:0]    qa_q, qa_d;
  logic [PosW-1:0]    qb_q, qb_d;
  logic [LetterW-1:0] ca_q, ca_d;
  logic               m_vld_q, m_vld_d;
  logic [CipherW-1:0] m_first_q, m_first_d;
  logic [CipherW-1:0] m_second_q, m_second_d;

  logic               accept;
  kind_e              kind;
  letter_t            in_let;
  logic               place_en;
  logic [LetterW-1:0] place_let;
  logic [LetterW-1:0] pos_raddr;
  logic [PosW-1:0]    pos_rdata;
  logic [PosW-1:0]    sq_raddr;
  logic [LetterW-1:0] sq_rdata;
  logic [RowW-1:0]    ra, ca, rb, cb;
  logic               slot_free;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign kind            = kind_e'(s_axis_tuser_i);
  assign in_let          = letter_of(s_axis_tdata_i);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign slot_free       = !m_vld_q || m_axis_tready_i;

  // Square table: letter at each position, written in fill order.
  pde_ram #(
    .Width (LetterW),
    .Depth (Cells)
  ) u_square (
    .clk_i   (clk_i),
    .we_i    (place_en),
    .waddr_i (fill_q),
    .wdata_i (place_let),
    .raddr_i (sq_raddr),
    .rdata_o (sq_rdata)
  );

  // Position table: square position of each letter.
  pde_ram #(
    .Width (PosW),
    .Depth (Alpha)
  ) u_position (
    .clk_i   (clk_i),
    .we_i    (place_en),
    .waddr_i (place_let),
    .wdata_i (fill_q),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  // Placement of one letter, from a key word or from the alphabet sweep.
  always_comb begin
    place_en  = 1'b0;
    place_let = in_let.idx;
    if (state_q == ST_FILL) begin
      place_let = sweep_q;
      place_en  = (sweep_q != LetterJ) && !used_q[sweep_q] && (fill_q < PosW'(Cells));
    end else if (accept && kind == KIND_KEY) begin
      place_en  = !ready_q && in_let.vld && !used_q[in_let.idx] && (fill_q < PosW'(Cells));
    end
  end

  // Table read addresses follow the sequencer step.
  assign pos_raddr = (state_q == ST_PA) ? a_q : b_q;
  assign sq_raddr  = (state_q == ST_SA) ? qa_q : qb_q;

  // Row and column of both letters; the second position arrives in ST_PC.
  assign ra = pos_row(pa_q);
  assign ca = pos_col(pa_q);
  assign rb = pos_row(pos_rdata);
  assign cb = pos_col(pos_rdata);

  // Sequencer and datapath next state.
  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    fill_d     = fill_q;
    sweep_d    = sweep_q;
    ready_d    = ready_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    a_d        = a_q;
    b_d        = b_q;
    pa_d       = pa_q;
    qa_d       = qa_q;
    qb_d       = qb_q;
    ca_d       = ca_q;
    m_vld_d    = m_vld_q && !m_axis_tready_i;
    m_first_d  = m_first_q;
    m_second_d = m_second_q;

    if (place_en) begin
      used_d[place_let] = 1'b1;
      fill_d            = PosW'(fill_q + PosW'(1));
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_KEY: begin
            end
            KIND_KEY_END: begin
              if (!ready_q) begin
                sweep_d = '0;
                state_d = ST_FILL;
              end
            end
            KIND_TEXT: begin
              if (ready_q && in_let.vld) begin
                if (!pend_vld_q) begin
                  pend_d     = in_let.idx;
                  pend_vld_d = 1'b1;
                end else begin
                  a_d     = pend_q;
                  state_d = ST_PA;
                  if (pend_q == in_let.idx) begin
                    b_d = LetterX;
                  end else begin
                    b_d        = in_let.idx;
                    pend_vld_d = 1'b0;
                  end
                end
              end
            end
            KIND_TEXT_END: begin
              if (ready_q && pend_vld_q) begin
                a_d        = pend_q;
                b_d        = LetterX;
                pend_vld_d = 1'b0;
                state_d    = ST_PA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        sweep_d = LetterW'(sweep_q + LetterW'(1));
        if (sweep_q == LetterW'(Alpha - 1)) begin
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_PA: begin
        state_d = ST_PB;
      end
      ST_PB: begin
        pa_d    = pos_rdata;
        state_d = ST_PC;
      end
      ST_PC: begin
        // Same row, same column or rectangle rule.
        priority if (ra == rb) begin
          qa_d = PosW'(row_base(ra) + PosW'(wrap_inc(ca)));
          qb_d = PosW'(row_base(rb) + PosW'(wrap_inc(cb)));
        end else if (ca == cb) begin
          qa_d = PosW'(row_base(wrap_inc(ra)) + PosW'(ca));
          qb_d = PosW'(row_base(wrap_inc(rb)) + PosW'(cb));
        end else begin
          qa_d = PosW'(row_base(ra) + PosW'(cb));
          qb_d = PosW'(row_base(rb) + PosW'(ca));
        end
        state_d = ST_SA;
      end
      ST_SA: begin
        state_d = ST_SB;
      end
      ST_SB: begin
        ca_d    = sq_rdata;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Hold the second letter on the read port until the output word is free.
        if (slot_free) begin
          m_vld_d    = 1'b1;
          m_first_d  = CipherW'(CipherA + CipherW'(ca_q));
          m_second_d = CipherW'(CipherA + CipherW'(sq_rdata));
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      fill_q     <= '0;
      sweep_q    <= '0;
      ready_q    <= 1'b0;
      pend_q     <= '0;
      pend_vld_q <= 1'b0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      fill_q     <= fill_d;
      sweep_q    <= sweep_d;
      ready_q    <= ready_d;
      pend_q     <= pend_d;
      pend_vld_q <= pend_vld_d;
      m_vld_q    <= m_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    pa_q       <= pa_d;
    qa_q       <= qa_d;
    qb_q       <= qb_d;
    ca_q       <= ca_d;
    m_first_q  <= m_first_d;
    m_second_q <= m_second_d;
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {2'b00, m_second_q, m_first_q};

  // Consistency checks.
  `include "playfair_digraph_encryptor_top_assert.svh"

  `PDE_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= PosW'(Cells), "fill count beyond square size")
  `PDE_ASSERT_IMP(a_ready_full, ready_q, fill_q == PosW'(Cells), "square ready but not full")
  `PDE_ASSERT_IMP(a_enc_ready, state_q == ST_PA, ready_q, "encryption started before key end")
  `PDE_ASSERT_NXT(a_out_load, state_q == ST_OUT && slot_free, m_vld_q && state_q == ST_IDLE,
                  "result word not loaded after final read")

endmodule

// ===== sim/tb_playfair_digraph_encryptor_top.sv =====
// Self-checking testbench for the Playfair digraph encryptor top level.
// Depends on pde_pkg and playfair_digraph_encryptor_top; a behavioral cipher predictor is built in.
`timescale 1ns / 1ps

module tb_playfair_digraph_encryptor_top
  import pde_pkg::*;
;

  localparam int RandItems   = 1350;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 200000;

  localparam logic [CipherW-1:0] CipherZ = CipherA + 7'd25;

  // One ciphertext pair as it leaves the block.
  typedef struct packed {
    logic [CipherW-1:0] first;
    logic [CipherW-1:0] second;
  } cipher_t;

  // Decoded input symbol: letter flag and letter index with J folded into I.
  typedef struct packed {
    logic               ok;
    logic [LetterW-1:0] idx;
  } glyph_t;

  // One directed stimulus row; the expected pair is given only where typed is set.
  typedef struct packed {
    kind_e              kind;
    logic [7:0]         sym;
    bit                 typed;
    bit                 has;
    logic [CipherW-1:0] first;
    logic [CipherW-1:0] second;
  } row_t;

  localparam int DirRows = 27;

  // Key PlAy, 0xFF, F, a, j, R, 0x00 gives the square
  // P L A Y F / I R B C D / E G H K M / N O Q S T / U V W X Z, so X enciphers as Z.
  localparam row_t DirTab [DirRows] = '{
    // Plaintext before the square is ready is dropped.
    '{KIND_TEXT,     "A",   1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_TEXT_END, 8'h00, 1'b1, 1'b0, 7'h00,   7'h00},
    // Key letters in both cases, non-letter extremes, a repeat and a lowercase j.
    '{KIND_KEY,      "P",   1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY,      "l",   1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY,      "A",   1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY,      "y",   1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY,      8'hFF, 1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY,      "F",   1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY,      "a",   1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY,      "j",   1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY,      "R",   1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY,      8'h00, 1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY_END,  8'hFF, 1'b1, 1'b0, 7'h00,   7'h00},
    // Key words after the key end are dropped.
    '{KIND_KEY,      "Z",   1'b1, 1'b0, 7'h00,   7'h00},
    '{KIND_KEY_END,  8'h00, 1'b1, 1'b0, 7'h00,   7'h00},
    // Doubled X, then the pending X padded at plaintext end, then an empty end.
    '{KIND_TEXT,     "x",   1'b0, 1'b0, 7'h00,   7'h00},
    '{KIND_TEXT,     "X",   1'b1, 1'b1, CipherZ, CipherZ},
    '{KIND_TEXT_END, 8'hFF, 1'b1, 1'b1, CipherZ, CipherZ},
    '{KIND_TEXT_END, 8'h00, 1'b1, 1'b0, 7'h00,   7'h00},
    // J folded into I and doubled, then same column, same row and rectangle pairs.
    '{KIND_TEXT,     "J",   1'b0, 1'b0, 7'h00,   7'h00},
    '{KIND_TEXT,     "i",   1'b0, 1'b0, 7'h00,   7'h00},
    '{KIND_TEXT,     "p",   1'b0, 1'b0, 7'h00,   7'h00},
    '{KIND_TEXT,     "@",   1'b0, 1'b0, 7'h00,   7'h00},
    '{KIND_TEXT,     "a",   1'b0, 1'b0, 7'h00,   7'h00},
    '{KIND_TEXT,     "f",   1'b0, 1'b0, 7'h00,   7'h00},
    '{KIND_TEXT,     "g",   1'b0, 1'b0, 7'h00,   7'h00},
    '{KIND_TEXT_END, 8'h7B, 1'b0, 1'b0, 7'h00,   7'h00}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [1:0]  s_axis_tuser = KIND_KEY;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // Predictor copy of the square and the pairing state.
  logic [LetterW-1:0] sq_letter [Cells];
  logic [PosW-1:0]    sq_pos [Alpha];
  bit                 sq_used [Alpha];
  int                 sq_fill = 0;
  bit                 sq_ready = 1'b0;
  logic [LetterW-1:0] pend_letter = '0;
  bit                 pend_vld = 1'b0;

  cipher_t cipher_q [$];
  int      err_cnt = 0;
  int      cycle_cnt = 0;
  bit      tx_idle_en = 1'b1;
  bit      rx_idle_en = 1'b1;
  bit      rx_hold_req = 1'b0;

  playfair_digraph_encryptor_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic glyph_t fold_glyph(logic [7:0] sym);
    glyph_t g;
    g.ok  = 1'b0;
    g.idx = '0;
    if (sym >= AsciiUpA && sym <= AsciiUpZ) begin
      g.ok  = 1'b1;
      g.idx = LetterW'(sym - AsciiUpA);
    end else if (sym >= AsciiLowA && sym <= AsciiLowZ) begin
      g.ok  = 1'b1;
      g.idx = LetterW'(sym - AsciiLowA);
    end
    if (g.idx == LetterJ) begin
      g.idx = LetterI;
    end
    return g;
  endfunction

  // Append a letter to the square unless it is already there or the square is full.
  task automatic place_letter(input logic [LetterW-1:0] l);
    if (sq_fill < Cells && !sq_used[l]) begin
      sq_used[l]         = 1'b1;
      sq_letter[sq_fill] = l;
      sq_pos[l]          = PosW'(sq_fill);
      sq_fill++;
    end
  endtask

  // Same row shifts right, same column shifts down, otherwise swap columns.
  function automatic cipher_t encrypt_digraph(logic [LetterW-1:0] a, logic [LetterW-1:0] b);
    int      pa, pb, ra, ca, rb, cb, qa, qb;
    cipher_t res;
    pa = int'(sq_pos[a]);
    pb = int'(sq_pos[b]);
    ra = pa / Side;
    ca = pa % Side;
    rb = pb / Side;
    cb = pb % Side;
    if (ra == rb) begin
      qa = ra * Side + (ca + 1) % Side;
      qb = rb * Side + (cb + 1) % Side;
    end else if (ca == cb) begin
      qa = ((ra + 1) % Side) * Side + ca;
      qb = ((rb + 1) % Side) * Side + cb;
    end else begin
      qa = ra * Side + cb;
      qb = rb * Side + ca;
    end
    res.first  = CipherA + CipherW'(sq_letter[qa]);
    res.second = CipherA + CipherW'(sq_letter[qb]);
    return res;
  endfunction

  // Advance the predictor by one accepted word and report the pair it yields.
  task automatic predict_word(input kind_e k, input logic [7:0] sym,
                              output bit has, output cipher_t ct);
    glyph_t g;
    int     i;
    g   = fold_glyph(sym);
    has = 1'b0;
    ct  = '0;
    case (k)
      KIND_KEY: begin
        if (!sq_ready && g.ok) begin
          place_letter(g.idx);
        end
      end
      KIND_KEY_END: begin
        if (!sq_ready) begin
          for (i = 0; i < Alpha; i++) begin
            if (LetterW'(i) != LetterJ) begin
              place_letter(LetterW'(i));
            end
          end
          sq_ready = 1'b1;
        end
      end
      KIND_TEXT: begin
        if (sq_ready && g.ok) begin
          if (!pend_vld) begin
            pend_letter = g.idx;
            pend_vld    = 1'b1;
          end else if (pend_letter == g.idx) begin
            // Doubled letter: split by X, the second copy stays pending.
            ct  = encrypt_digraph(pend_letter, LetterX);
            has = 1'b1;
          end else begin
            ct       = encrypt_digraph(pend_letter, g.idx);
            has      = 1'b1;
            pend_vld = 1'b0;
          end
        end
      end
      default: begin
        if (sq_ready && pend_vld) begin
          ct       = encrypt_digraph(pend_letter, LetterX);
          has      = 1'b1;
          pend_vld = 1'b0;
        end
      end
    endcase
  endtask

  // Offer one word after a random gap and queue its expected pair once accepted.
  task automatic send_word(input kind_e k, input logic [7:0] sym, input bit typed,
                           input bit typed_has, input cipher_t typed_ct);
    int      gap;
    bit      has;
    cipher_t ct;
    gap = tx_idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= sym;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(k, sym, has, ct);
    if (typed) begin
      has = typed_has;
      ct  = typed_ct;
    end
    if (has) begin
      cipher_q.push_back(ct);
    end
  endtask

  // Sender: reset, directed table, then random plaintext runs.
  initial begin : stim
    int         n;
    int         j;
    int         run_len;
    int         pick;
    int         idx;
    int         prev;
    int         count;
    bit         hold_done;
    bit         pause_done;
    row_t       row;
    cipher_t    typed_ct;
    logic [7:0] sym;
    count      = 0;
    prev       = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < DirRows; n++) begin
      row             = DirTab[n];
      typed_ct.first  = row.first;
      typed_ct.second = row.second;
      send_word(row.kind, row.sym, row.typed, row.has, typed_ct);
    end

    while (count < RandItems) begin
      // Long receiver hold with a busy sender, then a drained pause and a gap-free stretch.
      if (!hold_done && count >= 400) begin
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        tx_idle_en  = 1'b0;
      end
      if (count >= 550 && count < 700) begin
        tx_idle_en = 1'b1;
      end
      if (!pause_done && count >= 700) begin
        pause_done    = 1'b1;
        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if (count >= 1000) begin
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
      end

      run_len = $urandom_range(1, 24);
      for (j = 0; j < run_len; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_word(KIND_TEXT, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end else if (pick < 9) begin
          send_word($urandom_range(0, 1) ? KIND_KEY_END : KIND_KEY,
                    8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        end else begin
          // Favor repeats and X so that splits and X pads occur often.
          if (pick < 24) begin
            idx = prev;
          end else if (pick < 32) begin
            idx = int'(LetterX);
          end else begin
            idx = $urandom_range(0, Alpha - 1);
          end
          prev = idx;
          sym  = ($urandom_range(0, 1) ? AsciiLowA : AsciiUpA) + 8'(idx);
          send_word(KIND_TEXT, sym, 1'b0, 1'b0, '0);
        end
        count++;
      end
      if ($urandom_range(0, 3) != 0) begin
        send_word(KIND_TEXT_END, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
        count++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: random ready gaps per word, plus one long hold on request.
  initial begin : sink
    int gap;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      gap = rx_idle_en ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare every accepted result word with the oldest expected pair.
  always @(posedge clk_i) begin : cipher_check
    cipher_t got;
    cipher_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.first  = m_axis_tdata[6:0];
      got.second = m_axis_tdata[13:7];
      if (cipher_q.size() == 0) begin
        $error("result word with no pair expected: first_cipher %h second_cipher %h",
               got.first, got.second);
        err_cnt++;
      end else begin
        want = cipher_q.pop_front();
        if (got.first != want.first) begin
          $error("first_cipher mismatch: expected %h, actual %h", want.first, got.first);
          err_cnt++;
        end
        if (got.second != want.second) begin
          $error("second_cipher mismatch: expected %h, actual %h", want.second, got.second);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== playfair_digraph_encryptor_top.f =====
+incdir+rtl
rtl/pde_pkg.sv
rtl/pde_ram.sv
rtl/playfair_digraph_encryptor_top.sv
sim/tb_playfair_digraph_encryptor_top.sv
